@@ rtl/tgc_pkg.sv @@
// tgc_pkg: shared types, codes and reset values for the touch gesture classifier
// no dependencies; imported by tgc_cfg_regs, tgc_classify and the top level
package tgc_pkg;

	localparam int TimeW  = 32;
	localparam int DebW   = 10;
	localparam int HoldW  = 16;
	localparam int GestW  = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// gesture codes
	localparam logic [GestW-1:0] GEST_SINGLE = 2'd0;
	localparam logic [GestW-1:0] GEST_DOUBLE = 2'd1;
	localparam logic [GestW-1:0] GEST_LONG   = 2'd2;

	// request kinds
	localparam logic REQ_EDGE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_DOUBLE_TAP  = 3'd3;

	// register reset values
	localparam logic             RST_ACTIVE_LOW = 1'b1;
	localparam logic [DebW-1:0]  RST_DEBOUNCE   = 10'd15;
	localparam logic [HoldW-1:0] RST_LONG_PRESS = 16'd500;
	localparam logic [HoldW-1:0] RST_DOUBLE_TAP = 16'd300;

	typedef struct packed {
		logic             active_low;
		logic [DebW-1:0]  debounce_ms;
		logic [HoldW-1:0] long_press_ms;
		logic [HoldW-1:0] double_tap_ms;
	} cfg_t;

	typedef struct packed {
		logic             req_type;
		logic             pin_level;
		logic [TimeW-1:0] time_ms;
	} item_t;

endpackage

@@ rtl/tgc_cfg_regs.sv @@
// tgc_cfg_regs: configuration register file of the touch gesture classifier
// depends on tgc_pkg (cfg_t, register indexes, reset values)
module tgc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tgc_pkg::CfgIdxW-1:0]    wr_index,
	input  logic [tgc_pkg::CfgDataW-1:0]   wr_data,
	output tgc_pkg::cfg_t                  cfg
);
	import tgc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low    <= RST_ACTIVE_LOW;
			cfg_q.debounce_ms   <= RST_DEBOUNCE;
			cfg_q.long_press_ms <= RST_LONG_PRESS;
			cfg_q.double_tap_ms <= RST_DOUBLE_TAP;
		end else if (wr_en) begin
			// indexes past the list are dropped
			unique case (wr_index)
				CFG_ACTIVE_LOW: cfg_q.active_low    <= wr_data[0];
				CFG_DEBOUNCE:   cfg_q.debounce_ms   <= wr_data[DebW-1:0];
				CFG_LONG_PRESS: cfg_q.long_press_ms <= wr_data[HoldW-1:0];
				CFG_DOUBLE_TAP: cfg_q.double_tap_ms <= wr_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tgc_classify.sv @@
// tgc_classify: gesture state registers and the single-pass update for one beat
// depends on tgc_pkg (cfg_t, item_t, gesture and request codes)
module tgc_classify (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tgc_pkg::cfg_t               cfg,
	input  tgc_pkg::item_t              item,
	input  logic                        fire,
	output logic                        res_hit,
	output logic [tgc_pkg::GestW-1:0]   res_gesture
);
	import tgc_pkg::*;

	logic             touching_q, long_fired_q, tap_count_q;
	logic [TimeW-1:0] touch_start_q, last_change_q, pending_q;

	logic             touching_d, long_fired_d, tap_count_d;
	logic [TimeW-1:0] touch_start_d, last_change_d, pending_d;

	logic             pressed;
	logic [TimeW-1:0] d_last, d_start, d_pend;
	logic             pend_any, in_window, debounced, held;

	// wrapping differences against the stored times
	assign pressed   = cfg.active_low ? ~item.pin_level : item.pin_level;
	assign d_last    = item.time_ms - last_change_q;
	assign d_start   = item.time_ms - touch_start_q;
	assign d_pend    = item.time_ms - pending_q;
	assign pend_any  = (pending_q != '0);
	assign debounced = (d_last >= {{(TimeW-DebW){1'b0}}, cfg.debounce_ms});
	assign held      = (d_start >= {{(TimeW-HoldW){1'b0}}, cfg.long_press_ms});
	assign in_window = (d_pend <= {{(TimeW-HoldW){1'b0}}, cfg.double_tap_ms});

	always_comb begin
		touching_d    = touching_q;
		long_fired_d  = long_fired_q;
		tap_count_d   = tap_count_q;
		touch_start_d = touch_start_q;
		last_change_d = last_change_q;
		pending_d     = pending_q;
		res_hit       = 1'b0;
		res_gesture   = GEST_SINGLE;
		unique case (item.req_type)
			REQ_EDGE: begin
				if ((pressed != touching_q) && debounced) begin
					last_change_d = item.time_ms;
					if (pressed) begin
						touching_d    = 1'b1;
						long_fired_d  = 1'b0;
						touch_start_d = item.time_ms;
					end else begin
						touching_d = 1'b0;
						if (!long_fired_q) begin
							if (pend_any && in_window) begin
								pending_d   = '0;
								tap_count_d = 1'b0;
								res_hit     = 1'b1;
								res_gesture = GEST_DOUBLE;
							end else begin
								pending_d   = item.time_ms;
								tap_count_d = 1'b1;
							end
						end
					end
				end
			end
			REQ_TICK: begin
				priority if (touching_q && !long_fired_q && held) begin
					long_fired_d = 1'b1;
					pending_d    = '0;
					tap_count_d  = 1'b0;
					res_hit      = 1'b1;
					res_gesture  = GEST_LONG;
				end else if (pend_any && !in_window) begin
					pending_d = '0;
					if (tap_count_q) begin
						tap_count_d = 1'b0;
						res_hit     = 1'b1;
						res_gesture = GEST_SINGLE;
					end
				end else begin
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touching_q    <= 1'b0;
			long_fired_q  <= 1'b0;
			tap_count_q   <= 1'b0;
			touch_start_q <= '0;
			last_change_q <= '0;
			pending_q     <= '0;
		end else if (fire) begin
			touching_q    <= touching_d;
			long_fired_q  <= long_fired_d;
			tap_count_q   <= tap_count_d;
			touch_start_q <= touch_start_d;
			last_change_q <= last_change_d;
			pending_q     <= pending_d;
		end
	end

endmodule

@@ rtl/touch_gesture_classifier_core.sv @@
// touch_gesture_classifier_core: top level of the tap / double tap / long press classifier
// depends on tgc_pkg, tgc_cfg_regs and tgc_classify
//
//   channel  handshake              payload                        direction
//   in       in_valid / in_ready    req_type, pin_level, time_ms   into block
//   out      out_valid / out_ready  gesture                        out of block
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data            into block
//
// one beat per clock unless the out channel stalls: an input beat is captured in the
// stage register, classified there and its gesture (if any) lands in the output register
// as the beat advances, so a gesture is valid from the edge at which its beat advanced
// the stage register only moves on when the output register is empty or being
// drained, so a stalled out channel holds one gesture and one waiting input beat
// arst_n clears valids, gesture state and loads the register reset values
// cfg_ready is always high; a write lands in its register at the accepting edge
module touch_gesture_classifier_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic                                pin_level,
	input  logic [tgc_pkg::TimeW-1:0]           time_ms,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tgc_pkg::GestW-1:0]           gesture,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tgc_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [tgc_pkg::CfgDataW-1:0]        cfg_data
);
	import tgc_pkg::*;

	cfg_t             cfg;
	item_t            item_s1;
	logic             valid_s1;
	logic             advance;
	logic             res_hit;
	logic [GestW-1:0] res_gesture;
	logic             out_valid_q;
	logic [GestW-1:0] gesture_q;

	// register file, always ready
	assign cfg_ready = 1'b1;

	tgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage beat leaves when the output register can take its gesture
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req_type  <= req_type;
			item_s1.pin_level <= pin_level;
			item_s1.time_ms   <= time_ms;
		end
	end

	// classification and state update, committed when the beat advances
	tgc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item        (item_s1),
		.fire        (advance),
		.res_hit     (res_hit),
		.res_gesture (res_gesture)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_hit) begin
			gesture_q <= res_gesture;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

endmodule
